// File: sv/byte_ring_fifo_overwrite_assert.svh
// assertion macros for the byte ring fifo back end
// no dependencies; brfo_back includes this header to check its own logic
`ifndef BYTE_RING_FIFO_OVERWRITE_ASSERT_SVH
`define BYTE_RING_FIFO_OVERWRITE_ASSERT_SVH

`ifndef ASSERT_OFF
// condition a implies condition c in the same cycle
`define BRFO_ASSERT_IMPLIES(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
// condition a implies condition c in the next cycle
`define BRFO_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`else
`define BRFO_ASSERT_IMPLIES(label, clk, rst, a, c)
`define BRFO_ASSERT_NEXT(label, clk, rst, a, c)
`endif

`endif

// File: sv/brfo_pkg.sv
// shared types, codes and defaults for the byte ring fifo with overwrite
// no dependencies
package brfo_pkg;

   // default sizes
   localparam int DEPTH_DEFAULT    = 256;
   localparam int MAX_READ_DEFAULT = 64;

   // field widths
   localparam int OP_W   = 2;
   localparam int BYTE_W = 8;
   localparam int LEN_W  = 7;

   // operation codes on the request channel
   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   // classified command kinds
   localparam int KIND_W = 2;
   localparam logic [KIND_W-1:0] CMD_STATUS = 2'd0;
   localparam logic [KIND_W-1:0] CMD_WRITE  = 2'd1;
   localparam logic [KIND_W-1:0] CMD_READ   = 2'd2;
   localparam logic [KIND_W-1:0] CMD_CLEAR  = 2'd3;

   // command passed from front to back
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] data;
      logic [LEN_W-1:0]  len;
   } cmd_type;

   // one result beat
   typedef struct packed {
      logic [BYTE_W-1:0] read_byte;
      logic              data_valid;
      logic              last;
      logic              empty_flag;
      logic              full_flag;
      logic              overflow_flag;
   } rsp_type;

endpackage

// File: sv/brfo_ifs.sv
// valid/ready channel interfaces for the request and result sides
// depends on brfo_pkg for field widths
interface brfo_req_if;
   logic                          valid;
   logic                          ready;
   logic [brfo_pkg::OP_W-1:0]     operation;
   logic [brfo_pkg::BYTE_W-1:0]   write_byte;
   logic [brfo_pkg::LEN_W-1:0]    read_length;

   modport source (output valid, operation, write_byte, read_length, input ready);
   modport sink   (input valid, operation, write_byte, read_length, output ready);
endinterface

interface brfo_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [brfo_pkg::BYTE_W-1:0]   read_byte;
   logic                          data_valid;
   logic                          last;
   logic                          empty_flag;
   logic                          full_flag;
   logic                          overflow_flag;

   modport source (output valid, read_byte, data_valid, last, empty_flag, full_flag,
                   overflow_flag, input ready);
   modport sink   (input valid, read_byte, data_valid, last, empty_flag, full_flag,
                   overflow_flag, output ready);
endinterface

// File: sv/byte_ring_fifo_overwrite.sv
// top level of the byte ring fifo with overwrite of the oldest byte
// depends on brfo_pkg, brfo_ifs, brfo_front, brfo_cmdq and brfo_back
//
// Byte receive fifo on a DEPTH-entry circular store. Each request beat is a
// write of one byte, a read of up to read_length bytes (clamped to MAX_READ)
// or a clear. A write to a full store overwrites the oldest byte, sets the
// overflow flag and moves the read pointer along with the write pointer.
// Writes, clears, unused codes and reads that return nothing give one status
// beat (data_valid low, last high). A read returning n bytes gives n beats
// with last on the final one: the store's registered read port fetches the
// first byte, then one byte per cycle follows while the result slot is free.
// Commands are executed one at a time; a two-entry command queue lets
// requests be accepted while the back end is busy or the result register
// is stalled. Pointers and flags come out of reset at once; the byte store
// has no reset and needs no clearing pass.
module byte_ring_fifo_overwrite #(
   parameter int DEPTH    = brfo_pkg::DEPTH_DEFAULT,
   parameter int MAX_READ = brfo_pkg::MAX_READ_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   brfo_req_if.sink    req_bus,
   brfo_rsp_if.source  rsp_bus
);

   logic              fq_valid, fq_ready;
   brfo_pkg::cmd_type fq_cmd;
   logic              qb_valid, qb_ready;
   brfo_pkg::cmd_type qb_cmd;

   // classify incoming requests
   brfo_front #(
      .MAX_READ (MAX_READ)
   ) u_front (
      .req_bus   (req_bus),
      .cmd_valid (fq_valid),
      .cmd_ready (fq_ready),
      .cmd       (fq_cmd)
   );

   // decouple front and back
   brfo_cmdq u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_cmd    (fq_cmd),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_cmd   (qb_cmd)
   );

   // execute commands on the store
   brfo_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (qb_valid),
      .cmd_ready (qb_ready),
      .cmd       (qb_cmd),
      .rsp_bus   (rsp_bus)
   );

endmodule

// File: sv/brfo_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies; read returns the old data on a same-address write
module brfo_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: sv/brfo_front.sv
// front end: accepts request beats and classifies them into commands
// depends on brfo_pkg and brfo_ifs
module brfo_front #(
   parameter int MAX_READ = brfo_pkg::MAX_READ_DEFAULT
) (
   brfo_req_if.sink           req_bus,
   output logic               cmd_valid,
   input  logic               cmd_ready,
   output brfo_pkg::cmd_type  cmd
);

   localparam logic [brfo_pkg::LEN_W-1:0] MAX_LEN = brfo_pkg::LEN_W'(MAX_READ);

   // decode operation and clamp read length
   always_comb begin
      cmd.data = req_bus.write_byte;
      cmd.len  = '0;
      unique case (req_bus.operation)
         brfo_pkg::OP_WRITE: cmd.kind = brfo_pkg::CMD_WRITE;
         brfo_pkg::OP_READ: begin
            cmd.kind = brfo_pkg::CMD_READ;
            cmd.len  = (req_bus.read_length > MAX_LEN) ? MAX_LEN : req_bus.read_length;
         end
         brfo_pkg::OP_CLEAR: cmd.kind = brfo_pkg::CMD_CLEAR;
         default: cmd.kind = brfo_pkg::CMD_STATUS;
      endcase
   end

   assign cmd_valid     = req_bus.valid;
   assign req_bus.ready = cmd_ready;

endmodule

// File: sv/brfo_cmdq.sv
// two-entry command queue between the front and back ends
// depends on brfo_pkg
module brfo_cmdq (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  brfo_pkg::cmd_type  in_cmd,
   output logic               out_valid,
   input  logic               out_ready,
   output brfo_pkg::cmd_type  out_cmd
);

   brfo_pkg::cmd_type entry_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_cmd   = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

// File: sv/brfo_back.sv
// back end: owns the byte store, pointers and flags, and emits result beats
// depends on brfo_pkg, brfo_ifs, brfo_ram and the assertion header
`include "byte_ring_fifo_overwrite_assert.svh"

module brfo_back #(
   parameter int DEPTH = brfo_pkg::DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   output logic               cmd_ready,
   input  brfo_pkg::cmd_type  cmd,
   brfo_rsp_if.source         rsp_bus
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   logic                         state_ff, state_in;
   logic [PTR_W-1:0]             wp_ff, wp_in;
   logic [PTR_W-1:0]             rp_ff, rp_in;
   logic                         empty_ff, empty_in;
   logic                         full_ff, full_in;
   logic                         ovf_ff, ovf_in;
   logic [brfo_pkg::LEN_W-1:0]   cnt_ff, cnt_in;
   logic                         out_valid_ff, out_valid_in;
   brfo_pkg::rsp_type            out_ff, out_in;

   logic                         slot_free;
   logic                         ram_we;
   logic [brfo_pkg::BYTE_W-1:0]  ram_rdata;
   logic [PTR_W-1:0]             w_next, r_next;
   logic                         w_ovf, w_full, r_stop, r_last;

   assign slot_free = !out_valid_ff || rsp_bus.ready;
   assign cmd_ready = (state_ff == ST_IDLE) && slot_free;

   // next pointer values and flags for a write and for one read byte
   assign w_next = advance(wp_ff);
   assign w_ovf  = ovf_ff || (full_ff && (wp_ff == rp_ff));
   assign w_full = full_ff || (w_next == rp_ff);
   assign r_next = advance(rp_ff);
   assign r_stop = (r_next == wp_ff);
   assign r_last = r_stop || (cnt_ff == brfo_pkg::LEN_W'(1));

   // command execution
   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      empty_in     = empty_ff;
      full_in      = full_ff;
      ovf_in       = ovf_ff;
      cnt_in       = cnt_ff;
      ram_we       = 1'b0;
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      out_in       = out_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && slot_free) begin
               out_valid_in     = 1'b1;
               out_in.read_byte = '0;
               out_in.data_valid = 1'b0;
               out_in.last      = 1'b1;
               unique case (cmd.kind)
                  brfo_pkg::CMD_WRITE: begin
                     ram_we   = 1'b1;
                     wp_in    = w_next;
                     ovf_in   = w_ovf;
                     full_in  = w_full;
                     empty_in = 1'b0;
                     rp_in    = w_ovf ? w_next : rp_ff;
                  end
                  brfo_pkg::CMD_CLEAR: begin
                     wp_in    = '0;
                     rp_in    = '0;
                     empty_in = 1'b1;
                     full_in  = 1'b0;
                     ovf_in   = 1'b0;
                  end
                  brfo_pkg::CMD_READ: begin
                     // store read port primes on rp this cycle
                     if (!empty_ff && (cmd.len != '0)) begin
                        out_valid_in = 1'b0;
                        state_in     = ST_RUN;
                        cnt_in       = cmd.len;
                     end
                  end
                  default: begin
                  end
               endcase
               out_in.empty_flag    = empty_in;
               out_in.full_flag     = full_in;
               out_in.overflow_flag = ovf_in;
               if (!out_valid_in) begin
                  out_in = out_ff;
               end
            end
         end
         ST_RUN: begin
            // one byte per free output slot
            if (slot_free) begin
               rp_in    = r_next;
               full_in  = 1'b0;
               ovf_in   = 1'b0;
               empty_in = r_stop;
               cnt_in   = cnt_ff - brfo_pkg::LEN_W'(1);
               if (r_last) begin
                  state_in = ST_IDLE;
               end
               out_valid_in         = 1'b1;
               out_in.read_byte     = ram_rdata;
               out_in.data_valid    = 1'b1;
               out_in.last          = r_last;
               out_in.empty_flag    = r_stop;
               out_in.full_flag     = 1'b0;
               out_in.overflow_flag = 1'b0;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         rp_ff        <= '0;
         empty_ff     <= 1'b1;
         full_ff      <= 1'b0;
         ovf_ff       <= 1'b0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         empty_ff     <= empty_in;
         full_ff      <= full_in;
         ovf_ff       <= ovf_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // result payload register
   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   // byte store, read address follows the next read pointer
   brfo_ram #(
      .WIDTH (brfo_pkg::BYTE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (wp_ff),
      .wdata (cmd.data),
      .raddr (rp_in),
      .rdata (ram_rdata)
   );

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.read_byte     = out_ff.read_byte;
   assign rsp_bus.data_valid    = out_ff.data_valid;
   assign rsp_bus.last          = out_ff.last;
   assign rsp_bus.empty_flag    = out_ff.empty_flag;
   assign rsp_bus.full_flag     = out_ff.full_flag;
   assign rsp_bus.overflow_flag = out_ff.overflow_flag;

   // flag and pointer consistency
   `BRFO_ASSERT_IMPLIES(a_empty_full_excl, clock, reset, empty_ff, !full_ff)
   `BRFO_ASSERT_IMPLIES(a_ovf_needs_full, clock, reset, ovf_ff, full_ff)
   `BRFO_ASSERT_IMPLIES(a_full_ptrs_meet, clock, reset, full_ff || empty_ff, wp_ff == rp_ff)
   `BRFO_ASSERT_IMPLIES(a_run_has_data, clock, reset, state_ff == ST_RUN,
                        !empty_ff && (cnt_ff != '0))

endmodule

// File: verif/byte_ring_fifo_overwrite_checker.sv
// result checker for the byte ring fifo with overwrite of the oldest byte
// depends on brfo_pkg and brfo_ifs; watches both channels, tracks the ring and compares beats
module byte_ring_fifo_overwrite_checker (
   input  logic  clock,
   input  logic  reset,
   brfo_req_if   req_bus,
   brfo_rsp_if   rsp_bus,
   output int    fail_count,
   output int    beats_due_count
);
   import brfo_pkg::*;

   localparam int PTR_W = $clog2(DEPTH_DEFAULT);

   // shadow copy of the ring, its pointers and flags
   logic [BYTE_W-1:0] ring [DEPTH_DEFAULT];
   logic [PTR_W-1:0]  wr_ptr;
   logic [PTR_W-1:0]  rd_ptr;
   logic              empty_q;
   logic              full_q;
   logic              ovf_q;

   // result beats owed by the block, oldest first
   rsp_type due_beats[$];
   int      errors = 0;

   assign fail_count = errors;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
      errors++;
   endtask

   // queue one beat carrying the flags as they stand now
   task automatic owe_beat(input logic [BYTE_W-1:0] data, input logic valid_byte,
                           input logic is_last);
      rsp_type beat;
      beat.read_byte     = data;
      beat.data_valid    = valid_byte;
      beat.last          = is_last;
      beat.empty_flag    = empty_q;
      beat.full_flag     = full_q;
      beat.overflow_flag = ovf_q;
      due_beats.push_back(beat);
   endtask

   // advance the shadow ring by one request and record the beats it owes
   task automatic apply_fifo_op(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] wb,
                                input logic [LEN_W-1:0] len);
      int               want_n;
      int               count;
      logic             stop;
      logic [BYTE_W-1:0] data;
      case (op)
         OP_WRITE: begin
            // a write onto a full ring overwrites the oldest byte
            if (full_q && wr_ptr == rd_ptr)
               ovf_q = 1'b1;
            ring[wr_ptr] = wb;
            wr_ptr = wr_ptr + 1'b1;
            if (wr_ptr == rd_ptr)
               full_q = 1'b1;
            empty_q = 1'b0;
            if (ovf_q)
               rd_ptr = wr_ptr;
            owe_beat('0, 1'b0, 1'b1);
         end
         OP_READ: begin
            want_n = (int'(len) > MAX_READ_DEFAULT) ? MAX_READ_DEFAULT : int'(len);
            if (empty_q || want_n == 0) begin
               owe_beat('0, 1'b0, 1'b1);
            end else begin
               // one beat per byte, stop early once the ring runs dry
               count = 0;
               stop  = 1'b0;
               while (count < want_n && !stop) begin
                  data    = ring[rd_ptr];
                  rd_ptr  = rd_ptr + 1'b1;
                  full_q  = 1'b0;
                  ovf_q   = 1'b0;
                  stop    = (rd_ptr == wr_ptr);
                  if (stop)
                     empty_q = 1'b1;
                  owe_beat(data, 1'b1, stop || (count + 1 == want_n));
                  count++;
               end
            end
         end
         OP_CLEAR: begin
            wr_ptr  = '0;
            rd_ptr  = '0;
            empty_q = 1'b1;
            full_q  = 1'b0;
            ovf_q   = 1'b0;
            owe_beat('0, 1'b0, 1'b1);
         end
         default: begin
            owe_beat('0, 1'b0, 1'b1);
         end
      endcase
   endtask

   // compare one accepted result beat with the oldest one owed
   task automatic check_beat();
      rsp_type want;
      if (due_beats.size() == 0) begin
         report_mismatch("beat with nothing owed, read_byte", int'(rsp_bus.read_byte), 0);
      end else begin
         want = due_beats.pop_front();
         if (rsp_bus.read_byte !== want.read_byte)
            report_mismatch("read_byte", int'(rsp_bus.read_byte), int'(want.read_byte));
         if (rsp_bus.data_valid !== want.data_valid)
            report_mismatch("data_valid", int'(rsp_bus.data_valid), int'(want.data_valid));
         if (rsp_bus.last !== want.last)
            report_mismatch("last", int'(rsp_bus.last), int'(want.last));
         if (rsp_bus.empty_flag !== want.empty_flag)
            report_mismatch("empty_flag", int'(rsp_bus.empty_flag), int'(want.empty_flag));
         if (rsp_bus.full_flag !== want.full_flag)
            report_mismatch("full_flag", int'(rsp_bus.full_flag), int'(want.full_flag));
         if (rsp_bus.overflow_flag !== want.overflow_flag)
            report_mismatch("overflow_flag", int'(rsp_bus.overflow_flag),
                            int'(want.overflow_flag));
      end
   endtask

   // sample both channels on the rising edge
   always @(posedge clock) begin
      if (reset) begin
         wr_ptr  = '0;
         rd_ptr  = '0;
         empty_q = 1'b1;
         full_q  = 1'b0;
         ovf_q   = 1'b0;
         due_beats.delete();
      end else begin
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
            check_beat();
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1)
            apply_fifo_op(req_bus.operation, req_bus.write_byte, req_bus.read_length);
      end
      beats_due_count <= due_beats.size();
   end

endmodule

// File: verif/byte_ring_fifo_overwrite_tb.sv
// testbench top for the byte ring fifo with overwrite of the oldest byte
// depends on brfo_pkg, brfo_ifs, the block and byte_ring_fifo_overwrite_checker
module byte_ring_fifo_overwrite_tb;
   import brfo_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int LEN_MAX        = (1 << LEN_W) - 1;
   localparam int BYTE_MAX       = (1 << BYTE_W) - 1;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int TAIL_CYCLES    = 24;
   localparam int FIRST_MIX_END  = 90;
   localparam int LAST_MIX_END   = 360;

   logic clock = 1'b0;
   logic reset;

   brfo_req_if req_bus ();
   brfo_rsp_if rsp_bus ();

   int   fail_count;
   int   beats_due_count;
   int   items_sent  = 0;
   int   idle_cycles = 0;
   logic no_idle     = 1'b0;
   logic draining    = 1'b0;

   // result side stall state
   int   stall_left = 0;
   int   calm_left  = 0;
   int   ready_roll;

   byte_ring_fifo_overwrite dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   byte_ring_fifo_overwrite_checker fifo_check (
      .clock           (clock),
      .reset           (reset),
      .req_bus         (req_bus),
      .rsp_bus         (rsp_bus),
      .fail_count      (fail_count),
      .beats_due_count (beats_due_count)
   );

   // clock generation
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // result ready: short and long stalls with calm stretches between
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (draining || calm_left > 0) begin
         rsp_bus.ready <= 1'b1;
         if (calm_left > 0)
            calm_left--;
      end else if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_bus.ready <= 1'b1;
         ready_roll = $urandom_range(0, 99);
         if (ready_roll < 3)
            calm_left = $urandom_range(30, 120);
         else if (ready_roll < 25)
            stall_left = $urandom_range(1, 3);
         else if (ready_roll < 28)
            stall_left = $urandom_range(8, 40);
      end
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [BYTE_W-1:0] rand_byte();
      return BYTE_W'($urandom_range(0, BYTE_MAX));
   endfunction

   function automatic logic [LEN_W-1:0] rand_len();
      return LEN_W'($urandom_range(0, LEN_MAX));
   endfunction

   // mostly short lengths, with zero, the cap and above the cap now and then
   function automatic logic [LEN_W-1:0] pick_read_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return LEN_W'($urandom_range(1, 16));
      else if (r < 80)
         return '0;
      else if (r < 90)
         return LEN_W'(MAX_READ_DEFAULT);
      else
         return LEN_W'($urandom_range(MAX_READ_DEFAULT + 1, LEN_MAX));
   endfunction

   // sender gap: mostly none, some short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 65)
         return 0;
      else if (r < 92)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   // drive one request beat and hold it until accepted
   task automatic send_item(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] wb,
                            input logic [LEN_W-1:0] len);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.operation   <= op;
      req_bus.write_byte  <= wb;
      req_bus.read_length <= len;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      items_sent++;
   endtask

   // hold off the sender until every owed beat has come back
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (beats_due_count != 0);
   endtask

   // random mix of writes, reads, clears and the unused code
   task automatic mixed_traffic(input int upto);
      int r;
      int n;
      while (items_sent < upto) begin
         no_idle = ($urandom_range(0, 7) == 0);
         r = $urandom_range(0, 99);
         if (r < 45) begin
            n = $urandom_range(1, 12);
            repeat (n) send_item(OP_WRITE, rand_byte(), rand_len());
         end else if (r < 85) begin
            send_item(OP_READ, rand_byte(), pick_read_length());
         end else if (r < 91) begin
            send_item(OP_CLEAR, rand_byte(), rand_len());
         end else if (r < 96) begin
            send_item(OP_UNUSED, rand_byte(), rand_len());
         end else begin
            wait_drained();
         end
      end
      no_idle = 1'b0;
   endtask

   // fill the ring, read one byte off the full ring, refill, overwrite, drain
   task automatic overwrite_episode();
      int extra;
      extra = $urandom_range(1, 12);
      send_item(OP_CLEAR, rand_byte(), rand_len());
      repeat (DEPTH_DEFAULT) send_item(OP_WRITE, rand_byte(), rand_len());
      send_item(OP_READ, rand_byte(), LEN_W'(1));
      send_item(OP_WRITE, rand_byte(), rand_len());
      repeat (extra) send_item(OP_WRITE, rand_byte(), rand_len());
      wait_drained();
      repeat (5) send_item(OP_READ, rand_byte(), LEN_W'($urandom_range(MAX_READ_DEFAULT, LEN_MAX)));
   endtask

   initial begin
      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.operation    <= OP_WRITE;
      req_bus.write_byte   <= '0;
      req_bus.read_length  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: empty read, byte extremes, zero length, capped length, unused code, clear
      send_item(OP_READ, 8'h00, LEN_W'(5));
      send_item(OP_WRITE, 8'h00, LEN_W'(LEN_MAX));
      send_item(OP_WRITE, 8'hFF, '0);
      send_item(OP_WRITE, 8'hA5, LEN_W'(MAX_READ_DEFAULT));
      send_item(OP_READ, 8'hFF, '0);
      send_item(OP_READ, 8'h00, LEN_W'(1));
      send_item(OP_UNUSED, 8'hFF, LEN_W'(LEN_MAX));
      send_item(OP_READ, 8'h5A, LEN_W'(LEN_MAX));
      send_item(OP_READ, 8'h00, LEN_W'(MAX_READ_DEFAULT));
      send_item(OP_WRITE, 8'h5A, '0);
      send_item(OP_WRITE, 8'h01, '0);
      send_item(OP_CLEAR, 8'hFF, LEN_W'(LEN_MAX));
      send_item(OP_READ, 8'h00, LEN_W'(MAX_READ_DEFAULT));
      send_item(OP_WRITE, 8'h80, LEN_W'(MAX_READ_DEFAULT + 1));
      send_item(OP_READ, 8'h7F, LEN_W'(MAX_READ_DEFAULT));
      send_item(OP_UNUSED, 8'h00, '0);
      send_item(OP_CLEAR, 8'h00, '0);

      // random part with one full and overwrite episode in the middle
      mixed_traffic(FIRST_MIX_END);
      wait_drained();
      overwrite_episode();
      mixed_traffic(LAST_MIX_END);

      // drain, then give stray beats a chance to show up
      wait_drained();
      draining <= 1'b1;
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && beats_due_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
